/* rtl/core/gpio_register_block_top_macros.svh */
// Assertion macros for the GPIO register block.
// Used by gpio_register_block_top; expects clk and arst_n in scope.
`ifndef GPIO_REGISTER_BLOCK_TOP_MACROS_SVH
`define GPIO_REGISTER_BLOCK_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define GPIORB_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define GPIORB_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define GPIORB_ASSERT_IMP(label, ante, cons)
`define GPIORB_ASSERT_NXT(label, ante, cons)

`endif

`endif

/* rtl/core/gpiorb_pkg.sv */
// Shared constants, address map and types of the GPIO register block.
// No dependencies.
package gpiorb_pkg;

	// Pin count and derived widths.
	localparam int PIN_COUNT = 54;
	localparam int PULL_HI_W = 2 * (PIN_COUNT - 32);
	localparam int PULL_HI_PINS = PIN_COUNT - 32;

	// Function select words, ten 3-bit fields each.
	localparam int FSEL_DEPTH = 6;
	localparam int FSEL_IDX_W = $clog2(FSEL_DEPTH);
	localparam int FN_PER_WORD = 10;
	localparam logic [2:0] FN_IN = 3'd0;
	localparam logic [2:0] FN_OUT = 3'd1;

	// Plain read/write event and detect-enable words.
	localparam int EV_DEPTH = 14;
	localparam int EV_IDX_W = $clog2(EV_DEPTH);

	// Highest pull mode that is applied on a pull clock write.
	localparam logic [31:0] PULL_MAX = 32'd2;

	// Address map.
	localparam logic [7:0] ADDR_FSEL_LAST = 8'h14;
	localparam logic [7:0] ADDR_SET0 = 8'h1C;
	localparam logic [7:0] ADDR_SET1 = 8'h20;
	localparam logic [7:0] ADDR_CLR0 = 8'h28;
	localparam logic [7:0] ADDR_CLR1 = 8'h2C;
	localparam logic [7:0] ADDR_LEV0 = 8'h34;
	localparam logic [7:0] ADDR_LEV1 = 8'h38;
	localparam logic [7:0] ADDR_PMODE = 8'h94;
	localparam logic [7:0] ADDR_PCLK0 = 8'h98;
	localparam logic [7:0] ADDR_PCLK1 = 8'h9C;
	localparam logic [7:0] EV_ADDR [EV_DEPTH] = '{
		8'h40, 8'h44, 8'h4C, 8'h50, 8'h58, 8'h5C, 8'h64,
		8'h68, 8'h70, 8'h74, 8'h7C, 8'h80, 8'h88, 8'h8C
	};

	// Register class selected by an address.
	typedef enum logic [2:0] {
		K_BAD,
		K_FSEL,
		K_SET,
		K_CLR,
		K_LEVEL,
		K_EVENT,
		K_PMODE,
		K_PCLK
	} kind_t;

	// Decoded address: class plus word index (bank in bit 0 for pairs).
	typedef struct packed {
		kind_t kind;
		logic [EV_IDX_W-1:0] idx;
	} dec_t;

	// One result item.
	typedef struct packed {
		logic [31:0] rdata;
		logic bad;
		logic [PIN_COUNT-1:0] pin_out;
		logic [PIN_COUNT-1:0] pin_dir;
		logic [63:0] pull_low;
		logic [PULL_HI_W-1:0] pull_high;
	} res_t;

endpackage

/* rtl/core/gpiorb_decode.sv */
// Address decoder of the GPIO register block.
// Depends on gpiorb_pkg.
module gpiorb_decode import gpiorb_pkg::*; (
	input logic [7:0] addr,
	output dec_t dec
);

	// Map a byte offset to its register class and word index.
	always_comb begin
		dec.kind = K_BAD;
		dec.idx = '0;
		if (addr <= ADDR_FSEL_LAST && addr[1:0] == 2'b00) begin
			dec.kind = K_FSEL;
			dec.idx = EV_IDX_W'(addr[4:2]);
		end else if (addr == ADDR_SET0 || addr == ADDR_SET1) begin
			dec.kind = K_SET;
			dec.idx = EV_IDX_W'(addr == ADDR_SET1);
		end else if (addr == ADDR_CLR0 || addr == ADDR_CLR1) begin
			dec.kind = K_CLR;
			dec.idx = EV_IDX_W'(addr == ADDR_CLR1);
		end else if (addr == ADDR_LEV0 || addr == ADDR_LEV1) begin
			dec.kind = K_LEVEL;
			dec.idx = EV_IDX_W'(addr == ADDR_LEV1);
		end else if (addr == ADDR_PMODE) begin
			dec.kind = K_PMODE;
		end else if (addr == ADDR_PCLK0 || addr == ADDR_PCLK1) begin
			dec.kind = K_PCLK;
			dec.idx = EV_IDX_W'(addr == ADDR_PCLK1);
		end else begin
			for (int k = 0; k < EV_DEPTH; k++) begin
				if (addr == EV_ADDR[k]) begin
					dec.kind = K_EVENT;
					dec.idx = EV_IDX_W'(k);
				end
			end
		end
	end

endmodule

/* rtl/core/gpiorb_regs.sv */
// Register file and pin state of the GPIO register block.
// Computes one transaction's result and next state; depends on gpiorb_pkg.
module gpiorb_regs import gpiorb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic fire,
	input logic cmd,
	input dec_t dec,
	input logic [31:0] wdata,
	input logic [PIN_COUNT-1:0] pin_levels,
	output res_t res
);

	logic [FSEL_DEPTH-1:0][31:0] fsel_q, fsel_n;
	logic [63:0] set_q, set_w, set_n;
	logic [63:0] clr_q, clr_w, clr_n;
	logic [PIN_COUNT-1:0] lat_q, lat_n;
	logic [31:0] ev_q [EV_DEPTH];
	logic [31:0] ev_n [EV_DEPTH];
	logic [31:0] pmode_q, pmode_n;
	logic [1:0][31:0] pclk_q, pclk_n;
	logic [63:0] pull_lo_q, pull_lo_n;
	logic [PULL_HI_W-1:0] pull_hi_q, pull_hi_n;
	logic [PIN_COUNT-1:0] out_q, out_n;
	logic [PIN_COUNT-1:0] dir_q, dir_n;
	logic [2:0] fn_n [PIN_COUNT];
	logic [63:0] lat_w;
	logic wr_ok;

	// Function code of each pin from the updated select words.
	for (genvar g = 0; g < PIN_COUNT; g++) begin : g_fn
		localparam int W = g / FN_PER_WORD;
		localparam int B = 3 * (g % FN_PER_WORD);
		if (W < FSEL_DEPTH) begin : g_sel
			assign fn_n[g] = fsel_n[W][B +: 3];
		end else begin : g_none
			assign fn_n[g] = FN_IN;
		end
	end

	// Register writes, including the pull update on a pull clock write.
	always_comb begin
		fsel_n = fsel_q;
		set_w = set_q;
		clr_w = clr_q;
		ev_n = ev_q;
		pmode_n = pmode_q;
		pclk_n = pclk_q;
		pull_lo_n = pull_lo_q;
		pull_hi_n = pull_hi_q;
		wr_ok = cmd && dec.kind != K_BAD && dec.kind != K_LEVEL;
		if (cmd) begin
			unique case (dec.kind)
				K_FSEL: fsel_n[dec.idx[FSEL_IDX_W-1:0]] = wdata;
				K_SET: set_w[{dec.idx[0], 5'b0} +: 32] = wdata;
				K_CLR: clr_w[{dec.idx[0], 5'b0} +: 32] = wdata;
				K_EVENT: ev_n[dec.idx] = wdata;
				K_PMODE: pmode_n = wdata;
				K_PCLK: begin
					pclk_n[dec.idx[0]] = wdata;
					if (pmode_q <= PULL_MAX) begin
						if (!dec.idx[0]) begin
							for (int b = 0; b < 32; b++) begin
								if (wdata[b]) pull_lo_n[2*b +: 2] = pmode_q[1:0];
							end
						end else begin
							for (int b = 0; b < PULL_HI_PINS; b++) begin
								if (wdata[b]) pull_hi_n[2*b +: 2] = pmode_q[1:0];
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Pin update after every valid write; a pending bit is consumed when it drives an output pin.
	always_comb begin
		out_n = out_q;
		dir_n = dir_q;
		set_n = set_w;
		clr_n = clr_w;
		if (wr_ok) begin
			for (int i = 0; i < PIN_COUNT; i++) begin
				if (fn_n[i] == FN_OUT) begin
					dir_n[i] = 1'b1;
					if (set_w[i]) begin
						out_n[i] = 1'b1;
						set_n[i] = 1'b0;
					end else if (clr_w[i]) begin
						out_n[i] = 1'b0;
						clr_n[i] = 1'b0;
					end
				end else if (fn_n[i] == FN_IN) begin
					dir_n[i] = 1'b0;
				end
			end
		end
	end

	// A level read latches the external level of every input pin.
	always_comb begin
		lat_n = lat_q;
		if (!cmd && dec.kind == K_LEVEL) begin
			for (int i = 0; i < PIN_COUNT; i++) begin
				if (fn_n[i] == FN_IN) lat_n[i] = pin_levels[i];
			end
		end
		lat_w = 64'(lat_n);
	end

	// Read data and access check, plus the pin state after this transaction.
	always_comb begin
		res.rdata = '0;
		res.bad = 1'b0;
		if (!cmd) begin
			unique case (dec.kind)
				K_FSEL: res.rdata = fsel_q[dec.idx[FSEL_IDX_W-1:0]];
				K_LEVEL: res.rdata = lat_w[{dec.idx[0], 5'b0} +: 32];
				K_EVENT: res.rdata = ev_q[dec.idx];
				K_PMODE: res.rdata = pmode_q;
				K_PCLK: res.rdata = pclk_q[dec.idx[0]];
				default: res.bad = 1'b1;
			endcase
		end else begin
			res.bad = !wr_ok;
		end
		res.pin_out = out_n;
		res.pin_dir = dir_n;
		res.pull_low = pull_lo_n;
		res.pull_high = pull_hi_n;
	end

	// State registers, updated once per transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsel_q <= '0;
			set_q <= '0;
			clr_q <= '0;
			lat_q <= '0;
			for (int k = 0; k < EV_DEPTH; k++) ev_q[k] <= '0;
			pmode_q <= '0;
			pclk_q <= '0;
			pull_lo_q <= '0;
			pull_hi_q <= '0;
			out_q <= '0;
			dir_q <= '0;
		end else if (fire) begin
			fsel_q <= fsel_n;
			set_q <= set_n;
			clr_q <= clr_n;
			lat_q <= lat_n;
			ev_q <= ev_n;
			pmode_q <= pmode_n;
			pclk_q <= pclk_n;
			pull_lo_q <= pull_lo_n;
			pull_hi_q <= pull_hi_n;
			out_q <= out_n;
			dir_q <= dir_n;
		end
	end

endmodule

/* rtl/core/gpio_register_block_top.sv */
// GPIO register block, top level: input register, decode, register file, result register.
// The register file updates in a single pass between the input and result registers.
// Throughput: one transaction per cycle while out_ready is high.
// While a result waits, the input register holds one more transaction, then input stalls.
// Reset: all control and register state clears at once; no clearing pass is needed.
// Depends on gpiorb_pkg, gpiorb_decode, gpiorb_regs and the assertion macro header.
`include "gpio_register_block_top_macros.svh"

module gpio_register_block_top import gpiorb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic cmd,
	input logic [7:0] addr,
	input logic [31:0] wdata,
	input logic [PIN_COUNT-1:0] pin_levels,
	output logic out_valid,
	input logic out_ready,
	output logic [31:0] rdata,
	output logic bad_access,
	output logic [PIN_COUNT-1:0] pin_out,
	output logic [PIN_COUNT-1:0] pin_dir,
	output logic [63:0] pull_low,
	output logic [PULL_HI_W-1:0] pull_high
);

	logic valid_s1;
	logic cmd_s1;
	logic [7:0] addr_s1;
	logic [31:0] wdata_s1;
	logic [PIN_COUNT-1:0] levels_s1;
	logic out_valid_q;
	res_t res_q;
	res_t res;
	dec_t dec;
	logic advance;

	// The input stage moves on when the result register is free or being emptied.
	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd;
			addr_s1 <= addr;
			wdata_s1 <= wdata;
			levels_s1 <= pin_levels;
		end
	end

	gpiorb_decode u_decode (
		.addr(addr_s1),
		.dec(dec)
	);

	gpiorb_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.fire(advance),
		.cmd(cmd_s1),
		.dec(dec),
		.wdata(wdata_s1),
		.pin_levels(levels_s1),
		.res(res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_q <= res;
	end

	assign out_valid = out_valid_q;
	assign rdata = res_q.rdata;
	assign bad_access = res_q.bad;
	assign pin_out = res_q.pin_out;
	assign pin_dir = res_q.pin_dir;
	assign pull_low = res_q.pull_low;
	assign pull_high = res_q.pull_high;

	// A write transaction always returns zero read data.
	`GPIORB_ASSERT_NXT(a_write_rdata_zero, advance && cmd_s1, rdata == '0)
	// A write to a level word is flagged as a bad access.
	`GPIORB_ASSERT_NXT(a_level_write_bad, advance && cmd_s1 && dec.kind == K_LEVEL, bad_access)
	// A result appears only when the input stage hands one over.
	`GPIORB_ASSERT_NXT(a_out_from_stage, !out_valid_q && !advance, !out_valid_q)

endmodule
